// ----- sv/set_assoc_lru_cache_model_unit_macros.svh -----
// Assertion macros shared by the cache model RTL.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SALRU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SALRU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/salru_pkg.sv -----
// Shared types and constants of the set-associative LRU cache model.
package salru_pkg;

   // Fixed field widths.
   localparam int TAG_WIDTH   = 64;
   localparam int COUNT_WIDTH = 32;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STORE  = 2'd1,
      OP_MODIFY = 2'd2,
      OP_IFETCH = 2'd3
   } op_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS  = 2'd1;
   localparam logic [1:0] CSR_WAYS_IN_USE = 2'd2;

   // Configuration reset values.
   localparam logic [2:0] SET_BITS_RESET    = 3'd4;
   localparam logic [5:0] BLOCK_BITS_RESET  = 6'd4;
   localparam logic [3:0] WAYS_IN_USE_RESET = 4'd1;

   // Step control from the sequencer to the way scanner.
   typedef struct packed {
      logic step;
      logic first;
   } scan_ctrl_type;

   // Scanner status back to the sequencer.
   typedef struct packed {
      logic hit_now;
      logic hit;
      logic evict;
   } scan_status_type;

endpackage

// ----- sv/set_assoc_lru_cache_model_unit.sv -----
// Top level of the set-associative LRU cache model: sequencer, line memory and counters.
//
// Channel   Handshake              Payload
// request   start / busy           req_operation, req_address
// response  rsp_valid (strobe)     rsp_was_hit, rsp_was_eviction, rsp_last_of_item,
//                                  rsp_hit_total, rsp_miss_total, rsp_eviction_total
// csr       csr_valid / csr_ready  csr_index, csr_wdata
//
// A lookup splits the address, then reads and compares the ways in use one at a time
// through the single read port of the line memory (stopping early on a hit), and then
// writes the line. A load or store is one lookup, a modify two, and an instruction fetch
// starts no lookup.
// Each result strobes for one cycle, the cycle after its lookup's write.
// After reset a clearing pass writes all 2**MAX_SET_BITS * MAX_WAYS lines (512 by default),
// with busy high; configuration writes are taken throughout.
`include "set_assoc_lru_cache_model_unit_macros.svh"

module set_assoc_lru_cache_model_unit import salru_pkg::*; #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int STAMP_WIDTH  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_operation,
   input  logic [63:0]            req_address,
   // Response channel.
   output logic                   rsp_valid,
   output logic                   rsp_was_hit,
   output logic                   rsp_was_eviction,
   output logic                   rsp_last_of_item,
   output logic [COUNT_WIDTH-1:0] rsp_hit_total,
   output logic [COUNT_WIDTH-1:0] rsp_miss_total,
   output logic [COUNT_WIDTH-1:0] rsp_eviction_total,
   // Configuration channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [5:0]             csr_wdata
);

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int DEPTH    = NUM_SETS * MAX_WAYS;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SET_IW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int LINE_W   = 1 + TAG_WIDTH + STAMP_WIDTH;

   localparam logic [3:0]       SB_MAX    = 4'(MAX_SET_BITS);
   localparam logic [4:0]       WAYS_MAX  = 5'(MAX_WAYS);
   localparam logic [WAY_W-1:0] LAST_WAY  = WAY_W'(MAX_WAYS - 1);
   localparam logic [AW-1:0]    WAYS_AW   = AW'(MAX_WAYS);
   localparam logic [AW-1:0]    LAST_LINE = AW'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPLIT,
      ST_SCAN,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_ff;

   // Item and lookup registers.
   logic [63:0]            addr_ff;
   logic                   is_modify_ff;
   logic                   second_ff;
   logic [SET_IW-1:0]      set_ff;
   logic [TAG_WIDTH-1:0]   tag_ff;
   logic [WAY_W-1:0]       last_way_ff;
   logic [WAY_W-1:0]       iss_way_ff;
   logic                   iss_done_ff;
   logic                   cmp_valid_ff;
   logic [WAY_W-1:0]       cmp_way_ff;
   logic [AW-1:0]          clr_addr_ff;
   logic [STAMP_WIDTH-1:0] clock_ff;

   // Totals and response registers.
   logic [COUNT_WIDTH-1:0] hit_count_ff;
   logic [COUNT_WIDTH-1:0] miss_count_ff;
   logic [COUNT_WIDTH-1:0] evict_count_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic                   rsp_evict_ff;
   logic                   rsp_last_ff;

   // Address split signals.
   logic [3:0]           sb_eff;
   logic [63:0]          shifted;
   logic [SET_IW-1:0]    set_mask;
   logic [SET_IW-1:0]    set_split;
   logic [6:0]           tag_shift;
   logic [TAG_WIDTH-1:0] tag_split;
   logic [WAY_W-1:0]     last_way_split;

   // Memory and scanner signals.
   logic [AW-1:0]     base_addr;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic              rd_en;
   logic              wr_en;
   logic [LINE_W-1:0] wr_data;
   logic [LINE_W-1:0] rd_data;
   scan_ctrl_type     scan_ctrl;
   scan_status_type   scan_status;
   logic [WAY_W-1:0]  pick_way;
   logic              scan_end;

   // Split the address into set index and tag under the clamped configuration.
   assign sb_eff    = ({1'b0, set_bits_ff} > SB_MAX) ? SB_MAX : {1'b0, set_bits_ff};
   assign shifted   = addr_ff >> block_bits_ff;
   assign set_mask  = ~({SET_IW{1'b1}} << sb_eff);
   assign set_split = shifted[SET_IW-1:0] & set_mask;
   assign tag_shift = 7'(sb_eff) + 7'(block_bits_ff);
   assign tag_split = (tag_shift >= 7'd64) ? '0 : (addr_ff >> tag_shift);

   // Last way to scan, with zero taken as one way and large counts capped.
   always_comb begin
      if (ways_ff == 4'd0) begin
         last_way_split = '0;
      end else if ({1'b0, ways_ff} > WAYS_MAX) begin
         last_way_split = LAST_WAY;
      end else begin
         last_way_split = WAY_W'(ways_ff - 4'd1);
      end
   end

   // Line addresses: set row base plus way.
   assign base_addr = AW'(set_ff) * WAYS_AW;
   assign rd_addr   = base_addr + AW'(iss_way_ff);
   assign wr_addr   = (state_ff == ST_CLEAR) ? clr_addr_ff : base_addr + AW'(pick_way);
   assign rd_en     = (state_ff == ST_SCAN) && !iss_done_ff;
   assign wr_en     = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
   assign wr_data   = (state_ff == ST_CLEAR) ? '0 : {1'b1, tag_ff, clock_ff};

   salru_ram #(
      .WIDTH (LINE_W),
      .DEPTH (DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // One compare step for each line that comes back from the memory while the scan runs.
   assign scan_ctrl.step  = (state_ff == ST_SCAN) && cmp_valid_ff;
   assign scan_ctrl.first = (cmp_way_ff == '0);
   assign scan_end        = scan_ctrl.step && (scan_status.hit_now || cmp_way_ff == last_way_ff);

   salru_way_scan #(
      .WAY_W       (WAY_W),
      .STAMP_WIDTH (STAMP_WIDTH)
   ) u_way_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .way        (cmp_way_ff),
      .line_valid (rd_data[LINE_W-1]),
      .line_tag   (rd_data[LINE_W-2 -: TAG_WIDTH]),
      .line_stamp (rd_data[STAMP_WIDTH-1:0]),
      .ref_tag    (tag_ff),
      .status     (scan_status),
      .pick_way   (pick_way)
   );

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_LINE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && (req_operation != OP_IFETCH)) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = (is_modify_ff && !second_ff) ? ST_SPLIT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer state, configuration, item and lookup registers, counters and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         set_bits_ff    <= SET_BITS_RESET;
         block_bits_ff  <= BLOCK_BITS_RESET;
         ways_ff        <= WAYS_IN_USE_RESET;
         clock_ff       <= '0;
         hit_count_ff   <= '0;
         miss_count_ff  <= '0;
         evict_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         iss_done_ff    <= 1'b0;
         second_ff      <= 1'b0;
         is_modify_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;

         if (csr_valid) begin
            unique case (csr_index)
               CSR_SET_BITS:    set_bits_ff   <= csr_wdata[2:0];
               CSR_BLOCK_BITS:  block_bits_ff <= csr_wdata;
               CSR_WAYS_IN_USE: ways_ff       <= csr_wdata[3:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
            end
            ST_IDLE: begin
               if (start) begin
                  addr_ff      <= req_address;
                  is_modify_ff <= (req_operation == OP_MODIFY);
                  second_ff    <= 1'b0;
               end
            end
            ST_SPLIT: begin
               set_ff       <= set_split;
               tag_ff       <= tag_split;
               last_way_ff  <= last_way_split;
               clock_ff     <= clock_ff + 1'b1;
               iss_way_ff   <= '0;
               iss_done_ff  <= 1'b0;
               cmp_valid_ff <= 1'b0;
            end
            ST_SCAN: begin
               cmp_valid_ff <= !iss_done_ff;
               cmp_way_ff   <= iss_way_ff;
               if (!iss_done_ff) begin
                  iss_way_ff  <= iss_way_ff + 1'b1;
                  iss_done_ff <= (iss_way_ff == last_way_ff);
               end
            end
            ST_WRITE: begin
               if (scan_status.hit) begin
                  hit_count_ff <= hit_count_ff + 1'b1;
               end else begin
                  miss_count_ff <= miss_count_ff + 1'b1;
               end
               if (scan_status.evict) begin
                  evict_count_ff <= evict_count_ff + 1'b1;
               end
               rsp_valid_ff <= 1'b1;
               rsp_hit_ff   <= scan_status.hit;
               rsp_evict_ff <= scan_status.evict;
               rsp_last_ff  <= !(is_modify_ff && !second_ff);
               second_ff    <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Port drive.
   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_was_hit        = rsp_hit_ff;
   assign rsp_was_eviction   = rsp_evict_ff;
   assign rsp_last_of_item   = rsp_last_ff;
   assign rsp_hit_total      = hit_count_ff;
   assign rsp_miss_total     = miss_count_ff;
   assign rsp_eviction_total = evict_count_ff;

   // A lookup write is always followed by its result strobe.
   `SALRU_ASSERT_NEXT(a_write_gives_result, state_ff == ST_WRITE, rsp_valid_ff, "write without result")
   // A hit never replaces a valid line.
   `SALRU_ASSERT_NOW(a_hit_not_evict, rsp_valid_ff, !(rsp_hit_ff && rsp_evict_ff), "hit with eviction")
   // The first result of a modify is followed by the scan of its second lookup.
   `SALRU_ASSERT_NEXT(a_second_lookup, rsp_valid_ff && !rsp_last_ff, state_ff == ST_SCAN, "second lookup lost")
   // Compares never run past the last way in use.
   `SALRU_ASSERT_NOW(a_scan_in_range, scan_ctrl.step, cmp_way_ff <= last_way_ff, "scan past last way")

endmodule

// ----- sv/salru_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
module salru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/salru_way_scan.sv -----
// Way scanner: compares one line a step and keeps the hit, victim and eviction state.
module salru_way_scan import salru_pkg::*; #(
   parameter int WAY_W       = 3,
   parameter int STAMP_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scan_ctrl_type          ctrl,
   input  logic [WAY_W-1:0]       way,
   input  logic                   line_valid,
   input  logic [TAG_WIDTH-1:0]   line_tag,
   input  logic [STAMP_WIDTH-1:0] line_stamp,
   input  logic [TAG_WIDTH-1:0]   ref_tag,
   output scan_status_type        status,
   output logic [WAY_W-1:0]       pick_way
);

   logic                   hit_ff, hit_in;
   logic                   evict_ff, evict_in;
   logic [WAY_W-1:0]       pick_ff, pick_in;
   logic [STAMP_WIDTH-1:0] pick_stamp_ff, pick_stamp_in;
   logic                   match;
   logic [STAMP_WIDTH-1:0] base_stamp;

   assign match      = line_valid && (line_tag == ref_tag);
   assign base_stamp = ctrl.first ? line_stamp : pick_stamp_ff;

   // One scan step: a matching line wins, else an invalid line, else the oldest stamp.
   always_comb begin
      hit_in        = hit_ff;
      evict_in      = evict_ff;
      pick_in       = pick_ff;
      pick_stamp_in = pick_stamp_ff;
      if (ctrl.step) begin
         if (ctrl.first) begin
            hit_in        = 1'b0;
            evict_in      = line_valid;
            pick_in       = way;
            pick_stamp_in = line_stamp;
         end
         if (match) begin
            hit_in   = 1'b1;
            evict_in = 1'b0;
            pick_in  = way;
         end else if (!line_valid) begin
            evict_in      = 1'b0;
            pick_in       = way;
            pick_stamp_in = line_stamp;
         end else if (line_stamp < base_stamp) begin
            pick_in       = way;
            pick_stamp_in = line_stamp;
         end
      end
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         evict_ff <= 1'b0;
      end else begin
         hit_ff   <= hit_in;
         evict_ff <= evict_in;
      end
      pick_ff       <= pick_in;
      pick_stamp_ff <= pick_stamp_in;
   end

   assign status.hit_now = ctrl.step && match;
   assign status.hit     = hit_ff;
   assign status.evict   = evict_ff;
   assign pick_way       = pick_ff;

endmodule
